// ----- sv/lfpv_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and the sine table of the leg kinematics pipeline
// no dependencies; used by lfpv_kin and leg_foot_position_velocity_top
package lfpv_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  // first quadrant only, the other three are mirrored and negated from it
  localparam int QTAB_DEPTH = SINE_TABLE_DEPTH / 4;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned SERIES_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156, 64'd210};

  // register indexes
  localparam logic [2:0] REG_HIP_LAT = 3'd0;
  localparam logic [2:0] REG_THIGH   = 3'd1;
  localparam logic [2:0] REG_CALF    = 3'd2;
  localparam logic [2:0] REG_BODY_X  = 3'd3;
  localparam logic [2:0] REG_BODY_Y  = 3'd4;
  localparam logic [2:0] REG_BODY_Z  = 3'd5;

  typedef logic signed [16:0] sin_t;
  typedef sin_t sin_tab_t [QTAB_DEPTH];

  typedef struct packed {
    logic [15:0]        hip_lateral_offset;
    logic [15:0]        thigh_len;
    logic [15:0]        calf_len;
    logic signed [15:0] body_hip_x;
    logic signed [15:0] body_hip_y;
    logic signed [15:0] body_hip_z;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         leg_index;
    logic [15:0]        roll_angle;
    logic [15:0]        pitch_angle;
    logic [15:0]        knee_angle;
    logic signed [23:0] roll_rate;
    logic signed [23:0] pitch_rate;
    logic signed [23:0] knee_rate;
  } item_t;

  typedef struct packed {
    logic signed [19:0] foot_pos_x;
    logic signed [19:0] foot_pos_y;
    logic signed [19:0] foot_pos_z;
    logic signed [31:0] foot_vel_x;
    logic signed [31:0] foot_vel_y;
    logic signed [31:0] foot_vel_z;
  } result_t;

  // sin(r*pi/32768) for r in [0,16384], taylor series in q30, rounded to q1.15
  function automatic sin_t quarter_sine(longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    begin
      x = (r * PI_Q30) >> 15;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / SERIES_DIV[n];
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      if (sum > 32768) sum = 32768;
      return 17'(sum);
    end
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    longint unsigned u;
    begin
      for (int k = 0; k < QTAB_DEPTH; k++) begin
        u = ((longint'(k) * 65536) / SINE_TABLE_DEPTH) & 64'h3FFF;
        t[k] = quarter_sine(u);
      end
      return t;
    end
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();
  // value at a quarter turn, the one mirrored entry past the table's end
  localparam sin_t SIN_PEAK = quarter_sine(64'd16384);

  function automatic sin_t sin_lookup(logic [15:0] a);
    logic [31:0] p;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-3:0] r;
    sin_t mag;
    begin
      p = {16'b0, a} * 32'(SINE_TABLE_DEPTH);
      idx = p[16 +: IDX_W];
      r = idx[IDX_W-3:0];
      if (!idx[IDX_W-2]) mag = SIN_TAB[r];
      else if (r == '0) mag = SIN_PEAK;
      else mag = SIN_TAB[(IDX_W-2)'(QTAB_DEPTH - int'(r))];
      return idx[IDX_W-1] ? -mag : mag;
    end
  endfunction

  function automatic sin_t cos_lookup(logic [15:0] a);
    return sin_lookup(a + 16'd16384);
  endfunction

endpackage

// ----- sv/lfpv_kin.sv -----
`timescale 1ns / 1ps
// eight-stage kinematics datapath: table lookup, link products, jacobian,
// rate products and rounding; depends on lfpv_pkg
module lfpv_kin (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  lfpv_pkg::item_t   in_item,
  input  lfpv_pkg::cfg_t    cfg,
  output logic              out_valid,
  output lfpv_pkg::result_t out_res
);
  import lfpv_pkg::*;

  function automatic logic signed [19:0] rnd30_sat20(logic signed [51:0] v);
    logic signed [51:0] t;
    begin
      t = (v + 52'sd536870912) >>> 30;
      if (t > 52'sd524287) return 20'sh7FFFF;
      else if (t < -52'sd524288) return 20'sh80000;
      else return t[19:0];
    end
  endfunction

  function automatic logic signed [35:0] rnd15(logic signed [51:0] v);
    logic signed [51:0] t;
    begin
      t = (v + 52'sd16384) >>> 15;
      return t[35:0];
    end
  endfunction

  function automatic logic signed [31:0] rnd27_sat32(logic signed [61:0] v);
    logic signed [61:0] t;
    begin
      t = (v + 62'sd67108864) >>> 27;
      if (t > 62'sd2147483647) return 32'sh7FFFFFFF;
      else if (t < -62'sd2147483648) return 32'sh80000000;
      else return t[31:0];
    end
  endfunction

  logic [7:0] v_r;

  // rates and leg travel along the pipe
  logic [1:0]         leg_r [0:4];
  logic signed [23:0] dr_r [0:5];
  logic signed [23:0] dp_r [0:5];
  logic signed [23:0] dk_r [0:5];

  // stage 0
  logic [15:0] ang_r_r, ang_p_r, ang_pk_r;
  // stage 1
  sin_t s1_sr_r, s1_cr_r, s1_sp_r, s1_cp_r, s1_spk_r, s1_cpk_r;
  // stage 2
  logic signed [33:0] l2cp_r, l3cpk_r, l2sp_r, l3spk_r, l1cr_r, l1sr_r;
  sin_t s2_sr_r, s2_cr_r;
  logic signed [16:0] l1_nxt;
  // stage 3
  logic signed [34:0] a_r, b_r;
  logic signed [33:0] s3_l1cr_r, s3_l1sr_r, s3_l3cpk_r, s3_l3spk_r;
  sin_t s3_sr_r, s3_cr_r;
  // stage 4
  logic signed [51:0] sra_r, cra_r, srb_r, crb_r, l3spk_sr_r, l3spk_cr_r;
  logic signed [33:0] s4_l1cr_r, s4_l1sr_r, s4_l3cpk_r;
  logic signed [34:0] s4_a_r, s4_b_r;
  // stage 5
  logic signed [19:0] px_r, py_r, pz_r;
  logic signed [35:0] j01_r, j02_r, j10_r, j11_r, j12_r, j20_r, j21_r, j22_r;
  logic signed [51:0] px_nxt, py_nxt, pz_nxt;
  logic signed [16:0] fhbx_nxt, rlby_nxt;
  // stage 6
  logic signed [19:0] s6_px_r, s6_py_r, s6_pz_r;
  logic signed [59:0] m01_r, m02_r, m10_r, m11_r, m12_r, m20_r, m21_r, m22_r;
  // stage 7
  result_t res_r;

  always_comb begin
    l1_nxt = leg_r[1][0] ? $signed({1'b0, cfg.hip_lateral_offset})
                         : -$signed({1'b0, cfg.hip_lateral_offset});
    fhbx_nxt = leg_r[4][1] ? 17'(cfg.body_hip_x) : -17'(cfg.body_hip_x);
    rlby_nxt = leg_r[4][0] ? 17'(cfg.body_hip_y) : -17'(cfg.body_hip_y);
    px_nxt = -(52'(s4_b_r) <<< 15) + (52'(fhbx_nxt) <<< 30);
    py_nxt = (52'(s4_l1cr_r) <<< 15) + sra_r + (52'(rlby_nxt) <<< 30);
    pz_nxt = (52'(s4_l1sr_r) <<< 15) - cra_r + (52'(cfg.body_hip_z) <<< 30);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // s0
      leg_r[0] <= in_item.leg_index;
      dr_r[0] <= in_item.roll_rate;
      dp_r[0] <= in_item.pitch_rate;
      dk_r[0] <= in_item.knee_rate;
      ang_r_r <= in_item.roll_angle;
      ang_p_r <= in_item.pitch_angle;
      ang_pk_r <= in_item.pitch_angle + in_item.knee_angle;
      for (int i = 1; i < 5; i++) leg_r[i] <= leg_r[i-1];
      for (int i = 1; i < 6; i++) begin
        dr_r[i] <= dr_r[i-1];
        dp_r[i] <= dp_r[i-1];
        dk_r[i] <= dk_r[i-1];
      end
      // s1
      s1_sr_r <= sin_lookup(ang_r_r);
      s1_cr_r <= cos_lookup(ang_r_r);
      s1_sp_r <= sin_lookup(ang_p_r);
      s1_cp_r <= cos_lookup(ang_p_r);
      s1_spk_r <= sin_lookup(ang_pk_r);
      s1_cpk_r <= cos_lookup(ang_pk_r);
      // s2
      l2cp_r <= $signed({1'b0, cfg.thigh_len}) * s1_cp_r;
      l2sp_r <= $signed({1'b0, cfg.thigh_len}) * s1_sp_r;
      l3cpk_r <= $signed({1'b0, cfg.calf_len}) * s1_cpk_r;
      l3spk_r <= $signed({1'b0, cfg.calf_len}) * s1_spk_r;
      l1cr_r <= l1_nxt * s1_cr_r;
      l1sr_r <= l1_nxt * s1_sr_r;
      s2_sr_r <= s1_sr_r;
      s2_cr_r <= s1_cr_r;
      // s3
      a_r <= 35'(l2cp_r) + 35'(l3cpk_r);
      b_r <= 35'(l2sp_r) + 35'(l3spk_r);
      s3_l1cr_r <= l1cr_r;
      s3_l1sr_r <= l1sr_r;
      s3_l3cpk_r <= l3cpk_r;
      s3_l3spk_r <= l3spk_r;
      s3_sr_r <= s2_sr_r;
      s3_cr_r <= s2_cr_r;
      // s4
      sra_r <= 52'(s3_sr_r) * 52'(a_r);
      cra_r <= 52'(s3_cr_r) * 52'(a_r);
      srb_r <= 52'(s3_sr_r) * 52'(b_r);
      crb_r <= 52'(s3_cr_r) * 52'(b_r);
      l3spk_sr_r <= 52'(s3_l3spk_r) * 52'(s3_sr_r);
      l3spk_cr_r <= 52'(s3_l3spk_r) * 52'(s3_cr_r);
      s4_l1cr_r <= s3_l1cr_r;
      s4_l1sr_r <= s3_l1sr_r;
      s4_l3cpk_r <= s3_l3cpk_r;
      s4_a_r <= a_r;
      s4_b_r <= b_r;
      // s5
      px_r <= rnd30_sat20(px_nxt);
      py_r <= rnd30_sat20(py_nxt);
      pz_r <= rnd30_sat20(pz_nxt);
      j01_r <= -36'(s4_a_r);
      j02_r <= -36'(s4_l3cpk_r);
      j10_r <= rnd15(-(52'(s4_l1sr_r) <<< 15) + cra_r);
      j11_r <= rnd15(-srb_r);
      j12_r <= rnd15(-l3spk_sr_r);
      j20_r <= rnd15((52'(s4_l1cr_r) <<< 15) + sra_r);
      j21_r <= rnd15(crb_r);
      j22_r <= rnd15(l3spk_cr_r);
      // s6
      s6_px_r <= px_r;
      s6_py_r <= py_r;
      s6_pz_r <= pz_r;
      m01_r <= 60'(j01_r) * 60'(dp_r[5]);
      m02_r <= 60'(j02_r) * 60'(dk_r[5]);
      m10_r <= 60'(j10_r) * 60'(dr_r[5]);
      m11_r <= 60'(j11_r) * 60'(dp_r[5]);
      m12_r <= 60'(j12_r) * 60'(dk_r[5]);
      m20_r <= 60'(j20_r) * 60'(dr_r[5]);
      m21_r <= 60'(j21_r) * 60'(dp_r[5]);
      m22_r <= 60'(j22_r) * 60'(dk_r[5]);
      // s7
      res_r.foot_pos_x <= s6_px_r;
      res_r.foot_pos_y <= s6_py_r;
      res_r.foot_pos_z <= s6_pz_r;
      res_r.foot_vel_x <= rnd27_sat32(62'(m01_r) + 62'(m02_r));
      res_r.foot_vel_y <= rnd27_sat32(62'(m10_r) + 62'(m11_r) + 62'(m12_r));
      res_r.foot_vel_z <= rnd27_sat32(62'(m20_r) + 62'(m21_r) + 62'(m22_r));
    end
  end

  assign out_valid = v_r[7];
  assign out_res = res_r;

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_r[3] |=> v_r[4])
    else $error("valid bit lost between stages");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline moved during a stall");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> v_r == '0)
    else $error("valid bits not cleared by reset");

endmodule

// ----- sv/leg_foot_position_velocity_top.sv -----
`timescale 1ns / 1ps
// pipeline: eight register stages; throughput one item per cycle, the whole
// pipe advances whenever the output slot is free or being taken.
// reset (synchronous, active low) empties the pipe and clears all six
// registers to zero.
// top level: register file and stream ports; depends on lfpv_pkg, lfpv_kin
module leg_foot_position_velocity_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // roll_angle, pitch_angle, knee_angle, roll_rate, pitch_rate, knee_rate
  input  logic [119:0] in_tdata,
  // leg_index
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // foot_pos_x, foot_pos_y, foot_pos_z, foot_vel_x, foot_vel_y, foot_vel_z
  output logic [159:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);
  import lfpv_pkg::*;

  cfg_t    cfg_r;
  item_t   item;
  result_t res;
  logic    en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIP_LAT: cfg_r.hip_lateral_offset <= cfg_wdata;
        REG_THIGH:   cfg_r.thigh_len <= cfg_wdata;
        REG_CALF:    cfg_r.calf_len <= cfg_wdata;
        REG_BODY_X:  cfg_r.body_hip_x <= cfg_wdata;
        REG_BODY_Y:  cfg_r.body_hip_y <= cfg_wdata;
        REG_BODY_Z:  cfg_r.body_hip_z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  always_comb begin
    item.leg_index = in_tuser;
    item.roll_angle = in_tdata[15:0];
    item.pitch_angle = in_tdata[31:16];
    item.knee_angle = in_tdata[47:32];
    item.roll_rate = in_tdata[71:48];
    item.pitch_rate = in_tdata[95:72];
    item.knee_rate = in_tdata[119:96];
  end

  lfpv_kin u_kin (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_item  (item),
    .cfg      (cfg_r),
    .out_valid(out_tvalid),
    .out_res  (res)
  );

  assign out_tdata = {4'b0, res.foot_vel_z, res.foot_vel_y, res.foot_vel_x,
                      res.foot_pos_z, res.foot_pos_y, res.foot_pos_x};

endmodule
